[hdl/srtf_pkg.sv]
`default_nettype none

package srtf_pkg;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_LOAD    = 2'd0;
    localparam t_mode MODE_TICK    = 2'd1;
    localparam t_mode MODE_RESTART = 2'd2;

    // register index as decoded from paddr[2]
    localparam logic REG_TASKS_IN_USE = 1'b0;

    localparam logic [3:0] TASKS_IN_USE_RESET = 4'd7;
    localparam logic [3:0] DONE_COUNT_MAX     = 4'hF;

    typedef struct packed {
        t_mode       mode;
        logic [2:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  picked_slot;
        logic        idle;
        logic        finished_now;
        logic [3:0]  finished_count;
        logic        all_done;
        logic [31:0] wait_total;
        logic [31:0] turnaround_total;
        logic [31:0] time_now;
    } t_out_beat;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic clear;
        logic en;
    } t_pick_ctrl;

endpackage

`default_nettype wire

[hdl/srtf_alu.sv]
`default_nettype none

module srtf_alu (
    input  var srtf_pkg::t_alu_op i_op,
    input  wire logic [32:0]      i_a,
    input  wire logic [32:0]      i_b,
    output logic      [32:0]      o_sum,
    output logic                  o_neg,
    output logic      [31:0]      o_sat
);

    logic [33:0] w_y;

    always_comb begin
        unique case (i_op)
            srtf_pkg::ALU_ADD: w_y = {1'b0, i_a} + {1'b0, i_b};
            srtf_pkg::ALU_SUB: w_y = {1'b0, i_a} - {1'b0, i_b};
            default:           w_y = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end

    assign o_sum = w_y[32:0];
    assign o_neg = (i_op == srtf_pkg::ALU_SUB) && w_y[33];
    // clamp to 32 bits for the running totals
    assign o_sat = (|w_y[33:32]) ? 32'hFFFF_FFFF : w_y[31:0];

endmodule

`default_nettype wire

[hdl/srtf_slot_mem.sv]
`default_nettype none

module srtf_slot_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 48,
    parameter int AW    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    // never-loaded slots read as empty
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

`default_nettype wire

[hdl/srtf_pick_unit.sv]
`default_nettype none

module srtf_pick_unit #(
    parameter int TW = 16,
    parameter int AW = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  var srtf_pkg::t_pick_ctrl i_ctrl,
    input  wire logic [AW-1:0]       i_idx,
    input  wire logic [3*TW-1:0]     i_entry,
    input  wire logic [31:0]         i_time,
    output logic                     o_ran,
    output logic      [AW-1:0]       o_idx,
    output logic      [TW-1:0]       o_arr,
    output logic      [TW-1:0]       o_bur,
    output logic      [TW-1:0]       o_rem
);

    logic [TW-1:0] w_arr;
    logic [TW-1:0] w_bur;
    logic [TW-1:0] w_rem;
    logic          w_take;
    logic          r_ran;
    logic [AW-1:0] r_idx;
    logic [TW-1:0] r_arr;
    logic [TW-1:0] r_bur;
    logic [TW-1:0] r_rem;

    assign w_arr = i_entry[3*TW-1:2*TW];
    assign w_bur = i_entry[2*TW-1:TW];
    assign w_rem = i_entry[TW-1:0];

    // strict less-than keeps the lowest index on ties
    assign w_take = (w_rem != '0) && (32'(w_arr) <= i_time) && (!r_ran || (w_rem < r_rem));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ran <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_ran <= 1'b0;
        end else if (i_ctrl.en && w_take) begin
            r_ran <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en && w_take) begin
            r_idx <= i_idx;
            r_arr <= w_arr;
            r_bur <= w_bur;
            r_rem <= w_rem;
        end
    end

    assign o_ran = r_ran;
    assign o_idx = r_idx;
    assign o_arr = r_arr;
    assign o_bur = r_bur;
    assign o_rem = r_rem;

endmodule

`default_nettype wire

[hdl/srtf_tick_scheduler.sv]
`default_nettype none

// Preemptive shortest-remaining-time-first tick scheduler. One beat is taken
// at a time; the block stalls its input until that beat's result sits in the
// output register, which can still hold an untaken result while the next
// beat is accepted. Load, restart and unused-mode beats go from idle to done.
// A tick beat reads the first N = min(tasks_in_use, MAX_TASKS) slots of the
// slot memory one slot per cycle and compares each against the running best;
// a drain state then finishes the compare and a time state advances time,
// straight from idle when N is 0. A tick that completes its task then steps
// through TA, WT, TURN and WAIT, as the turnaround, waiting time and both
// saturating sums go one after another through the single shared 33-bit
// adder. All slots read as empty after reset; no clearing pass.
module srtf_tick_scheduler #(
    parameter int MAX_TASKS = 8,
    parameter int TIME_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  var srtf_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output srtf_pkg::t_out_beat     o_out_beat,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int ENT_W = 3 * TIME_BITS;
    localparam int CMP_W = ((IDX_W > 4) ? IDX_W : 4) + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_DRAIN = 9'b000000100,
        S_TIME  = 9'b000001000,
        S_TA    = 9'b000010000,
        S_WT    = 9'b000100000,
        S_TURN  = 9'b001000000,
        S_WAIT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [3:0]            r_tasks;
    logic [31:0]           r_time;
    logic [31:0]           r_wait;
    logic [31:0]           r_turn;
    logic [3:0]            r_done;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_cmp_en;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_fin;
    logic [32:0]           r_tplus;
    logic [32:0]           r_ta;
    logic [32:0]           r_wt;
    logic                  r_out_valid;
    srtf_pkg::t_out_beat   r_out_beat;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_cfg_wr;
    logic [CMP_W-1:0]      w_active;
    logic                  w_slot_ok;
    logic                  w_last;
    logic [TIME_BITS-1:0]  w_ld_arr;
    logic [TIME_BITS-1:0]  w_ld_bur;

    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [ENT_W-1:0]      w_wr_data;
    logic [ENT_W-1:0]      w_rd_data;

    srtf_pkg::t_pick_ctrl  w_pick_ctrl;
    logic                  w_pick_ran;
    logic [IDX_W-1:0]      w_pick_idx;
    logic [TIME_BITS-1:0]  w_pick_arr;
    logic [TIME_BITS-1:0]  w_pick_bur;
    logic [TIME_BITS-1:0]  w_pick_rem;
    logic                  w_pick_last;

    srtf_pkg::t_alu_op     w_alu_op;
    logic [32:0]           w_alu_a;
    logic [32:0]           w_alu_b;
    logic [32:0]           w_alu_sum;
    logic                  w_alu_neg;
    logic [31:0]           w_alu_sat;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2] == srtf_pkg::REG_TASKS_IN_USE);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == srtf_pkg::REG_TASKS_IN_USE) ? {28'd0, r_tasks} : 32'd0;

    assign w_active  = (CMP_W'(r_tasks) > CMP_W'(MAX_TASKS)) ? CMP_W'(MAX_TASKS)
                                                              : CMP_W'(r_tasks);
    assign w_slot_ok = CMP_W'(i_in_beat.slot) < CMP_W'(MAX_TASKS);
    assign w_last    = CMP_W'(r_idx) == (w_active - CMP_W'(1));
    assign w_ld_arr  = TIME_BITS'(i_in_beat.arrival);
    assign w_ld_bur  = TIME_BITS'(i_in_beat.burst);
    assign w_pick_last = w_pick_ran && (w_pick_rem == TIME_BITS'(1));

    // slot memory: loads from the input, decrement of the picked slot
    always_comb begin
        if (r_state == S_TIME) begin
            w_wr_en   = w_pick_ran;
            w_wr_addr = w_pick_idx;
            w_wr_data = {w_pick_arr, w_pick_bur, w_pick_rem - TIME_BITS'(1)};
        end else begin
            w_wr_en   = w_in_acc && (i_in_beat.mode == srtf_pkg::MODE_LOAD) && w_slot_ok;
            w_wr_addr = IDX_W'(i_in_beat.slot);
            w_wr_data = {w_ld_arr, w_ld_bur, w_ld_bur};
        end
    end

    srtf_slot_mem #(
        .DEPTH (MAX_TASKS),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (r_state == S_SCAN),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_pick_ctrl.clear = w_in_acc;
    assign w_pick_ctrl.en    = r_cmp_en;

    srtf_pick_unit #(
        .TW (TIME_BITS),
        .AW (IDX_W)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_pick_ctrl),
        .i_idx   (r_cmp_idx),
        .i_entry (w_rd_data),
        .i_time  (r_time),
        .o_ran   (w_pick_ran),
        .o_idx   (w_pick_idx),
        .o_arr   (w_pick_arr),
        .o_bur   (w_pick_bur),
        .o_rem   (w_pick_rem)
    );

    // shared adder operand select
    always_comb begin
        w_alu_op = srtf_pkg::ALU_ADD;
        w_alu_a  = '0;
        w_alu_b  = '0;
        unique case (r_state)
            S_TIME: begin
                w_alu_a = {1'b0, r_time};
                w_alu_b = 33'd1;
            end
            S_TA: begin
                w_alu_op = srtf_pkg::ALU_SUB;
                w_alu_a  = r_tplus;
                w_alu_b  = 33'(w_pick_arr);
            end
            S_WT: begin
                w_alu_op = srtf_pkg::ALU_SUB;
                w_alu_a  = r_ta;
                w_alu_b  = 33'(w_pick_bur);
            end
            S_TURN: begin
                w_alu_a = {1'b0, r_turn};
                w_alu_b = r_ta;
            end
            S_WAIT: begin
                w_alu_a = {1'b0, r_wait};
                w_alu_b = r_wt;
            end
            default: begin
                w_alu_a = '0;
            end
        endcase
    end

    srtf_alu u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_sum (w_alu_sum),
        .o_neg (w_alu_neg),
        .o_sat (w_alu_sat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_beat.mode == srtf_pkg::MODE_TICK) begin
                        n_state = (w_active == '0) ? S_TIME : S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_TIME;
            S_TIME:  n_state = w_pick_last ? S_TA : S_DONE;
            S_TA:    n_state = S_WT;
            S_WT:    n_state = S_TURN;
            S_TURN:  n_state = S_WAIT;
            S_WAIT:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tasks     <= srtf_pkg::TASKS_IN_USE_RESET;
            r_time      <= '0;
            r_wait      <= '0;
            r_turn      <= '0;
            r_done      <= '0;
            r_idx       <= '0;
            r_cmp_en    <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_en <= (r_state == S_SCAN);
            if (w_cfg_wr) begin
                r_tasks <= pwdata[3:0];
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_fin <= 1'b0;
                r_idx <= '0;
                if (i_in_beat.mode == srtf_pkg::MODE_RESTART) begin
                    r_time <= '0;
                    r_wait <= '0;
                    r_turn <= '0;
                    r_done <= '0;
                end
            end
            if (r_state == S_SCAN) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_state == S_TIME) begin
                r_time <= w_alu_sat;
                r_fin  <= w_pick_last;
            end
            if (r_state == S_TURN) begin
                r_turn <= w_alu_sat;
                if (r_done != srtf_pkg::DONE_COUNT_MAX) begin
                    r_done <= r_done + 4'd1;
                end
            end
            if (r_state == S_WAIT) begin
                r_wait <= w_alu_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_cmp_idx <= r_idx;
        end
        if (r_state == S_TIME) begin
            r_tplus <= w_alu_sum;
        end
        if (r_state == S_TA) begin
            r_ta <= w_alu_sum;
        end
        // waiting time below zero only after time saturated or a restart mid-task
        if (r_state == S_WT) begin
            r_wt <= w_alu_neg ? 33'd0 : w_alu_sum;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_beat.picked_slot      <= w_pick_ran ? 3'(w_pick_idx) : 3'd0;
            r_out_beat.idle             <= !w_pick_ran;
            r_out_beat.finished_now     <= r_fin;
            r_out_beat.finished_count   <= r_done;
            r_out_beat.all_done         <= (CMP_W'(r_done) == w_active);
            r_out_beat.wait_total       <= r_wait;
            r_out_beat.turnaround_total <= r_turn;
            r_out_beat.time_now         <= r_time;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

[verif/srtf_sched_checker.sv]
`default_nettype none

module srtf_sched_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  var  srtf_pkg::t_in_beat  i_in_beat,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  var  srtf_pkg::t_out_beat i_out_beat,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    input  wire logic [31:0]         prdata,
    input  wire logic                pready,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_completions
);

    localparam int SLOTS = 8;

    logic [15:0] arr_tbl [SLOTS];
    logic [15:0] bur_tbl [SLOTS];
    logic [15:0] rem_tbl [SLOTS];
    logic [31:0] now_ticks;
    logic [31:0] wait_acc;
    logic [31:0] turn_acc;
    logic [3:0]  done_cnt;
    logic [3:0]  tasks_cfg;

    srtf_pkg::t_out_beat sched_results_q [$];
    int                  errors = 0;
    int                  completions = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [32:0] b);
        logic [33:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // one scheduler step for an accepted input beat; queues its result
    task automatic schedule_step(input srtf_pkg::t_in_beat b);
        srtf_pkg::t_out_beat r;
        int                  n;
        logic                ran;
        logic                fin;
        logic [2:0]          pick;
        logic [15:0]         best;
        logic [32:0]         turn;
        logic [32:0]         wt;
        n    = (tasks_cfg > SLOTS) ? SLOTS : int'(tasks_cfg);
        ran  = 1'b0;
        fin  = 1'b0;
        pick = '0;
        best = '0;
        case (b.mode)
            srtf_pkg::MODE_LOAD: begin
                arr_tbl[b.slot] = b.arrival;
                bur_tbl[b.slot] = b.burst;
                rem_tbl[b.slot] = b.burst;
            end
            srtf_pkg::MODE_TICK: begin
                for (int i = 0; i < n; i++) begin
                    if ({16'b0, arr_tbl[i]} <= now_ticks && rem_tbl[i] != 0
                        && (!ran || rem_tbl[i] < best)) begin
                        best = rem_tbl[i];
                        pick = i[2:0];
                        ran  = 1'b1;
                    end
                end
                if (ran) begin
                    rem_tbl[pick] = rem_tbl[pick] - 16'd1;
                    if (rem_tbl[pick] == 0) begin
                        turn = {1'b0, now_ticks} + 33'd1 - {17'b0, arr_tbl[pick]};
                        wt   = (turn >= {17'b0, bur_tbl[pick]}) ?
                               turn - {17'b0, bur_tbl[pick]} : '0;
                        fin  = 1'b1;
                        if (done_cnt != srtf_pkg::DONE_COUNT_MAX)
                            done_cnt++;
                        wait_acc = sat_add32(wait_acc, wt);
                        turn_acc = sat_add32(turn_acc, turn);
                        completions++;
                    end
                end
                now_ticks = sat_add32(now_ticks, 33'd1);
            end
            srtf_pkg::MODE_RESTART: begin
                now_ticks = '0;
                wait_acc  = '0;
                turn_acc  = '0;
                done_cnt  = '0;
            end
            default: ;
        endcase
        r.picked_slot      = pick;
        r.idle             = !ran;
        r.finished_now     = fin;
        r.finished_count   = done_cnt;
        r.all_done         = (int'(done_cnt) == n);
        r.wait_total       = wait_acc;
        r.turnaround_total = turn_acc;
        r.time_now         = now_ticks;
        sched_results_q.push_back(r);
    endtask

    task automatic check_result(input srtf_pkg::t_out_beat got);
        srtf_pkg::t_out_beat want;
        if (sched_results_q.size() == 0) begin
            report("result beat with none pending", got.time_now, '0);
            return;
        end
        want = sched_results_q.pop_front();
        if (got.picked_slot !== want.picked_slot)
            report("picked_slot", got.picked_slot, want.picked_slot);
        if (got.idle !== want.idle)
            report("idle", got.idle, want.idle);
        if (got.finished_now !== want.finished_now)
            report("finished_now", got.finished_now, want.finished_now);
        if (got.finished_count !== want.finished_count)
            report("finished_count", got.finished_count, want.finished_count);
        if (got.all_done !== want.all_done)
            report("all_done", got.all_done, want.all_done);
        if (got.wait_total !== want.wait_total)
            report("wait_total", got.wait_total, want.wait_total);
        if (got.turnaround_total !== want.turnaround_total)
            report("turnaround_total", got.turnaround_total, want.turnaround_total);
        if (got.time_now !== want.time_now)
            report("time_now", got.time_now, want.time_now);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                arr_tbl[i] = '0;
                bur_tbl[i] = '0;
                rem_tbl[i] = '0;
            end
            now_ticks = '0;
            wait_acc  = '0;
            turn_acc  = '0;
            done_cnt  = '0;
            tasks_cfg = srtf_pkg::TASKS_IN_USE_RESET;
            sched_results_q.delete();
        end else begin
            // drain before queueing: a result never belongs to a beat taken at the same edge
            if (i_out_valid && !i_out_stall)
                check_result(i_out_beat);
            if (i_in_valid && !i_in_stall)
                schedule_step(i_in_beat);
            if (psel && penable && pready && paddr[2] == srtf_pkg::REG_TASKS_IN_USE) begin
                if (pwrite)
                    tasks_cfg = pwdata[3:0];
                else if (prdata !== {28'b0, tasks_cfg})
                    report("tasks_in_use readback", prdata, {28'b0, tasks_cfg});
            end
        end
        o_errors      <= errors;
        o_pending     <= sched_results_q.size();
        o_completions <= completions;
    end

endmodule

`default_nettype wire

[verif/tb_srtf_tick_scheduler.sv]
`default_nettype none

module tb_srtf_tick_scheduler;

    localparam int              CYCLE_LIMIT  = 500000;
    localparam int              PHASES       = 12;
    localparam int              PHASE_BEATS  = 100;
    localparam srtf_pkg::t_mode MODE_UNUSED  = 2'd3;
    localparam logic [2:0]      TASKS_ADDR   = {srtf_pkg::REG_TASKS_IN_USE, 2'b00};
    localparam logic [3:0]      SETTINGS_SEQ [6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5};

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    srtf_pkg::t_in_beat  i_in_beat   = '0;
    logic                i_out_stall = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [2:0]          paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    srtf_pkg::t_out_beat o_out_beat;
    logic [31:0]         prdata;
    logic                pready;

    int errors;
    int pending;
    int completions;

    int         cycles        = 0;
    int         beats_sent    = 0;
    int         ticks_sent    = 0;
    int         loads_sent    = 0;
    int         settings_used = 0;
    logic [3:0] tasks_now     = srtf_pkg::TASKS_IN_USE_RESET;
    logic       gaps_on       = 1'b0;
    int         run_left      = 0;
    int         stall_style   = 0;
    int         stall_left    = 0;

    always #6 i_clk = ~i_clk;

    srtf_tick_scheduler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    srtf_sched_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_beat     (i_in_beat),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_beat    (o_out_beat),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_completions (completions)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: the stall style is redrawn whenever its random run count runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_style)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 1) == 1);
            default: i_out_stall <= (stall_left % 5) < 2;
        endcase
    end

    task automatic send_beat(input srtf_pkg::t_mode mode, input logic [2:0] slot,
                             input logic [15:0] arrival, input logic [15:0] burst);
        if (gaps_on && run_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            run_left = $urandom_range(1, 12);
        end
        if (run_left > 0)
            run_left--;
        i_in_valid <= 1'b1;
        i_in_beat  <= srtf_pkg::t_in_beat'{mode, slot, arrival, burst};
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        if (mode == srtf_pkg::MODE_TICK)
            ticks_sent++;
        if (mode == srtf_pkg::MODE_LOAD)
            loads_sent++;
    endtask

    // pending is registered in the checker, so the loop polls it at each edge until it reads zero
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TASKS_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_tasks(input logic [3:0] v);
        apb_access(1'b1, {28'($urandom()), v});
        @(posedge i_clk);
        apb_access(1'b0, '0);
        tasks_now = v;
        settings_used++;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(3, 8))
            send_beat(srtf_pkg::t_mode'($urandom_range(0, 3)), 3'($urandom()),
                      16'($urandom()), 16'($urandom()));
    endtask

    // restart (mostly), load a task set, then tick it through with the odd preempting load
    task automatic run_workload();
        int          n;
        int          span;
        int          last_arr;
        int          rot;
        logic [15:0] a;
        logic [15:0] b;
        n        = (tasks_now > 8) ? 8 : int'(tasks_now);
        span     = 0;
        last_arr = 0;
        rot      = $urandom_range(0, 7);
        if ($urandom_range(0, 9) < 7)
            send_beat(srtf_pkg::MODE_RESTART, 3'($urandom()), 16'($urandom()),
                      16'($urandom()));
        for (int i = 0; i < 8; i++) begin
            if (i < n || $urandom_range(0, 3) == 0) begin
                a = 16'($urandom_range(0, 12));
                b = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                send_beat(srtf_pkg::MODE_LOAD, (n == 8) ? 3'(i + rot) : 3'(i), a, b);
                span += b;
                if (a > last_arr)
                    last_arr = a;
            end
        end
        for (int t = 0; t < span + last_arr + 3; t++) begin
            if ($urandom_range(0, 24) == 0)
                send_beat(srtf_pkg::MODE_LOAD, 3'($urandom_range(0, (n > 0) ? n - 1 : 0)),
                          16'($urandom_range(0, 4)), 16'($urandom_range(1, 3)));
            else
                send_beat(srtf_pkg::MODE_TICK, 3'($urandom()), 16'($urandom()),
                          16'($urandom()));
        end
    endtask

    initial begin
        logic [3:0] v;
        int         target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty tables, unused mode, tie on lowest index, slot beyond tasks_in_use,
        // task that never arrives, empty slot, restart keeping tables
        send_beat(srtf_pkg::MODE_TICK, 3'd5, 16'hFFFF, 16'hFFFF);
        send_beat(MODE_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF);
        send_beat(srtf_pkg::MODE_LOAD, 3'd0, 16'd0, 16'd3);
        send_beat(srtf_pkg::MODE_LOAD, 3'd1, 16'd0, 16'd3);
        send_beat(srtf_pkg::MODE_LOAD, 3'd2, 16'd2, 16'd1);
        send_beat(srtf_pkg::MODE_LOAD, 3'd7, 16'd0, 16'd1);
        send_beat(srtf_pkg::MODE_LOAD, 3'd3, 16'hFFFF, 16'hFFFF);
        send_beat(srtf_pkg::MODE_LOAD, 3'd4, 16'd0, 16'd0);
        repeat (9)
            send_beat(srtf_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0);
        send_beat(srtf_pkg::MODE_RESTART, 3'd0, 16'd0, 16'd0);
        send_beat(srtf_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0);
        send_beat(srtf_pkg::MODE_LOAD, 3'd5, 16'h8000, 16'h7FFF);
        send_beat(srtf_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            v = (phase < 6) ? SETTINGS_SEQ[phase] : 4'($urandom_range(0, 15));
            set_tasks(v);
            gaps_on  = ($urandom_range(0, 3) != 0);
            run_left = 0;
            target   = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                if ($urandom_range(0, 5) == 0)
                    send_noise();
                else
                    run_workload();
            end
        end
        wait_drained();
        repeat (30) @(posedge i_clk);

        $display("covered %0d beats (%0d ticks, %0d loads) under %0d tasks_in_use settings,",
                 beats_sent, ticks_sent, loads_sent, settings_used);
        $display("with %0d task completions checked against the predicted schedule",
                 completions);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
